/* hdl/lph_pkg.sv */
package lph_pkg;

  // Table size; must be a power of two so the home slot is the low key bits.
  localparam int SLOTS    = 16;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 34;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int PCNT_W   = 5;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_WRITE_IDX,
    DP_DISPLACE,
    DP_ADVANCE,
    DP_START_SHIFT,
    DP_SHIFT,
    DP_CLEAR_HOLE
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic                  res_set;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_count;
    logic                  res_data;
    logic                  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic full;
    logic key_match;
    logic home_eq;
    logic n_last;
  } dp_stat_t;

endpackage

/* hdl/lph_if.sv */
interface lph_req_if;
  logic                        valid;
  logic                        ready;
  logic [lph_pkg::FUNC_W-1:0]  func;
  logic [lph_pkg::KEY_W-1:0]   key;
  logic [lph_pkg::DATA_W-1:0]  payload;

  modport source (output valid, func, key, payload, input ready);
  modport sink   (input valid, func, key, payload, output ready);
endinterface

interface lph_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lph_pkg::STATUS_W-1:0]  status;
  logic [lph_pkg::PCNT_W-1:0]    probe_count;
  logic [lph_pkg::DATA_W-1:0]    found_payload;

  modport source (output valid, status, probe_count, found_payload, input ready);
  modport sink   (input valid, status, probe_count, found_payload, output ready);
endinterface

/* hdl/lph_dp.sv */
module lph_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lph_pkg::dp_cmd_t               cmd,
  output lph_pkg::dp_stat_t              stat,
  input  logic [lph_pkg::KEY_W-1:0]      key,
  input  logic [lph_pkg::DATA_W-1:0]     payload,
  output logic [lph_pkg::STATUS_W-1:0]   status,
  output logic [lph_pkg::PCNT_W-1:0]     probe_count,
  output logic [lph_pkg::DATA_W-1:0]     found_payload
);

  logic [lph_pkg::KEY_W-1:0]    mem_key  [lph_pkg::SLOTS];
  logic [lph_pkg::DATA_W-1:0]   mem_data [lph_pkg::SLOTS];
  logic [lph_pkg::SLOTS-1:0]    slot_valid;

  logic [lph_pkg::IDX_W-1:0]    idx;
  logic [lph_pkg::IDX_W-1:0]    hole;
  logic [lph_pkg::CNT_W-1:0]    n;
  logic [lph_pkg::KEY_W-1:0]    wk;
  logic [lph_pkg::DATA_W-1:0]   wd;
  logic [lph_pkg::KEY_W-1:0]    rd_key;
  logic [lph_pkg::DATA_W-1:0]   rd_data;

  logic [lph_pkg::STATUS_W-1:0] pend_status;
  logic [lph_pkg::PCNT_W-1:0]   pend_count;
  logic [lph_pkg::DATA_W-1:0]   pend_data;
  logic [lph_pkg::PCNT_W-1:0]   n_sat;

  logic                         wr_en;
  logic [lph_pkg::IDX_W-1:0]    wr_addr;
  logic [lph_pkg::KEY_W-1:0]    wr_key;
  logic [lph_pkg::DATA_W-1:0]   wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_key  = wk;
    wr_data = wd;
    case (cmd.op)
      lph_pkg::DP_WRITE_IDX, lph_pkg::DP_DISPLACE: begin
        wr_en = 1'b1;
      end
      lph_pkg::DP_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = hole;
        wr_key  = rd_key;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // single write port, single registered read port at the probe cursor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_data[wr_addr] <= wr_data;
    end
    rd_key  <= mem_key[idx];
    rd_data <= mem_data[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      case (cmd.op)
        lph_pkg::DP_WRITE_IDX, lph_pkg::DP_DISPLACE: slot_valid[idx] <= 1'b1;
        lph_pkg::DP_CLEAR_HOLE:                      slot_valid[hole] <= 1'b0;
        default:                                     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lph_pkg::DP_LOAD: begin
        wk  <= key;
        wd  <= payload;
        idx <= key[lph_pkg::IDX_W-1:0];
        n   <= lph_pkg::CNT_W'(1);
      end
      lph_pkg::DP_DISPLACE: begin
        // evicted occupant restarts probing from its own home
        wk  <= rd_key;
        wd  <= rd_data;
        idx <= rd_key[lph_pkg::IDX_W-1:0];
      end
      lph_pkg::DP_ADVANCE: begin
        idx <= idx + lph_pkg::IDX_W'(1);
        n   <= n + lph_pkg::CNT_W'(1);
      end
      lph_pkg::DP_START_SHIFT: begin
        hole <= idx;
        idx  <= idx + lph_pkg::IDX_W'(1);
        n    <= lph_pkg::CNT_W'(1);
      end
      lph_pkg::DP_SHIFT: begin
        hole <= idx;
        idx  <= idx + lph_pkg::IDX_W'(1);
        n    <= n + lph_pkg::CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign n_sat = (32'(n) > 32'd31) ? lph_pkg::PCNT_W'(31) : lph_pkg::PCNT_W'(n);

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      pend_status <= cmd.res_status;
      pend_count  <= cmd.res_count ? n_sat : '0;
      pend_data   <= cmd.res_data ? rd_data : '0;
    end
    if (cmd.emit) begin
      status        <= pend_status;
      probe_count   <= pend_count;
      found_payload <= pend_data;
    end
  end

  assign stat.cur_valid = slot_valid[idx];
  assign stat.full      = &slot_valid;
  assign stat.key_match = (rd_key == wk);
  assign stat.home_eq   = (rd_key[lph_pkg::IDX_W-1:0] == wk[lph_pkg::IDX_W-1:0]);
  assign stat.n_last    = (n == lph_pkg::CNT_W'(lph_pkg::SLOTS));

  a_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lph_pkg::DP_WRITE_IDX |-> !slot_valid[idx])
    else $error("insert overwrote a live slot");

  a_displace_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lph_pkg::DP_DISPLACE |-> slot_valid[idx] && !stat.home_eq)
    else $error("displacement of an empty or home-resident slot");

  a_shift_into_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lph_pkg::DP_SHIFT |-> slot_valid[hole] && slot_valid[idx])
    else $error("delete shift touched an empty slot");

  a_clear_one: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lph_pkg::DP_CLEAR_HOLE |=>
      $countones(slot_valid) == $countones($past(slot_valid)) - 1)
    else $error("delete did not free exactly one slot");

endmodule

/* hdl/lph_ctrl.sv */
module lph_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lph_pkg::FUNC_W-1:0]    func,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lph_pkg::dp_cmd_t              cmd,
  input  lph_pkg::dp_stat_t             stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_WAIT,
    S_INS_CHECK,
    S_PROBE,
    S_FIND_TEST,
    S_FIND_WAIT,
    S_FIND_CHECK,
    S_SHIFT_TEST,
    S_SHIFT_WAIT,
    S_SHIFT_CHECK,
    S_EMIT
  } state_t;

  state_t                     state, state_next;
  logic [lph_pkg::FUNC_W-1:0] op_func;
  logic                       out_free;

  // no request is taken while reset holds the engine
  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd.op         = lph_pkg::DP_NOP;
    cmd.res_set    = 1'b0;
    cmd.res_status = lph_pkg::ST_NOTFOUND;
    cmd.res_count  = 1'b0;
    cmd.res_data   = 1'b0;
    cmd.emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = lph_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_func)
          lph_pkg::FN_INSERT: begin
            if (stat.full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = lph_pkg::ST_FULL;
              state_next     = S_EMIT;
            end else if (!stat.cur_valid) begin
              cmd.op         = lph_pkg::DP_WRITE_IDX;
              cmd.res_set    = 1'b1;
              cmd.res_status = lph_pkg::ST_INSERTED;
              state_next     = S_EMIT;
            end else begin
              state_next = S_INS_WAIT;
            end
          end
          lph_pkg::FN_SEARCH, lph_pkg::FN_DELETE: begin
            state_next = S_FIND_TEST;
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = lph_pkg::ST_NOTFOUND;
            state_next     = S_EMIT;
          end
        endcase
      end
      S_INS_WAIT: begin
        state_next = S_INS_CHECK;
      end
      S_INS_CHECK: begin
        // occupant away from its home gives way to the new key
        if (!stat.home_eq) begin
          cmd.op = lph_pkg::DP_DISPLACE;
        end
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!stat.cur_valid) begin
          cmd.op         = lph_pkg::DP_WRITE_IDX;
          cmd.res_set    = 1'b1;
          cmd.res_status = lph_pkg::ST_INSERTED;
          state_next     = S_EMIT;
        end else begin
          cmd.op = lph_pkg::DP_ADVANCE;
        end
      end
      S_FIND_TEST: begin
        if (!stat.cur_valid) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = lph_pkg::ST_NOTFOUND;
          cmd.res_count  = (op_func == lph_pkg::FN_SEARCH);
          state_next     = S_EMIT;
        end else begin
          state_next = S_FIND_WAIT;
        end
      end
      S_FIND_WAIT: begin
        state_next = S_FIND_CHECK;
      end
      S_FIND_CHECK: begin
        if (stat.key_match) begin
          if (op_func == lph_pkg::FN_SEARCH) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = lph_pkg::ST_FOUND;
            cmd.res_count  = 1'b1;
            cmd.res_data   = 1'b1;
            state_next     = S_EMIT;
          end else begin
            cmd.op     = lph_pkg::DP_START_SHIFT;
            state_next = S_SHIFT_TEST;
          end
        end else if (stat.n_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = lph_pkg::ST_NOTFOUND;
          cmd.res_count  = (op_func == lph_pkg::FN_SEARCH);
          state_next     = S_EMIT;
        end else begin
          cmd.op     = lph_pkg::DP_ADVANCE;
          state_next = S_FIND_TEST;
        end
      end
      S_SHIFT_TEST: begin
        if (stat.n_last || !stat.cur_valid) begin
          cmd.op         = lph_pkg::DP_CLEAR_HOLE;
          cmd.res_set    = 1'b1;
          cmd.res_status = lph_pkg::ST_DELETED;
          state_next     = S_EMIT;
        end else begin
          state_next = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        state_next = S_SHIFT_CHECK;
      end
      S_SHIFT_CHECK: begin
        if (!stat.home_eq) begin
          cmd.op         = lph_pkg::DP_CLEAR_HOLE;
          cmd.res_set    = 1'b1;
          cmd.res_status = lph_pkg::ST_DELETED;
          state_next     = S_EMIT;
        end else begin
          cmd.op     = lph_pkg::DP_SHIFT;
          state_next = S_SHIFT_TEST;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op_func   <= lph_pkg::FN_INSERT;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        op_func <= func;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/linear_probe_hash_with_replacement.sv */
// Hash table of SLOTS entries with linear probing and replacement.
// req channel: func (insert / search / delete), key, payload. One request
// is taken at a time; req.ready is high only while the engine is idle.
// rsp channel: one response per request with status, probe_count and
// found_payload, held in an output register until rsp.ready.
// An insert into a free home slot, into a full table, or a request with an
// unknown func finishes right after dispatch; an insert that has to probe
// walks the table slot by slot (the evicted occupant's walk included). Search
// and delete lookups examine one slot after another from the key's home and
// end on an empty slot, on a match, or after SLOTS slots. A delete that finds
// its key pulls back the following entries of its home and stops at an empty
// slot or at an entry of another home.
// The walk is paced by the key/payload memory, with one write port and one
// registered read port. The next request is taken at the earliest on the edge
// where the response can first be taken, so a new request is never started
// before the last one is finished.
// Reset (synchronous, active high) empties the table by clearing the per-slot
// valid flags and drops any pending response.
// When the receiver stalls, the finished response waits in the output
// register; the next request is still taken and processed, and its result
// waits inside, blocking further requests, until the output register is free.
module linear_probe_hash_with_replacement (
  input logic         clk,
  input logic         rst,
  lph_req_if.sink     req,
  lph_rsp_if.source   rsp
);

  lph_pkg::dp_cmd_t  cmd;
  lph_pkg::dp_stat_t stat;

  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .func      (req.func),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lph_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .key           (req.key),
    .payload       (req.payload),
    .status        (rsp.status),
    .probe_count   (rsp.probe_count),
    .found_payload (rsp.found_payload)
  );

endmodule

/* tb/sv/tb_linear_probe_hash_with_replacement.sv */
`timescale 1ns / 1ps

module tb_linear_probe_hash_with_replacement;
  import lph_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;
  localparam int CNT_SAT     = (1 << PCNT_W) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 6 * SLOTS + 60;
  localparam int POOL_N      = 20;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PCNT_W-1:0]   probe_count;
    logic [DATA_W-1:0]   found_payload;
  } table_answer_t;

  logic clk;
  logic rst;

  lph_req_if req();
  lph_rsp_if rsp();

  linear_probe_hash_with_replacement DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the table
  logic [KEY_W-1:0]  tbl_key  [SLOTS];
  logic [DATA_W-1:0] tbl_data [SLOTS];
  bit                tbl_valid[SLOTS];

  table_answer_t expected_answers[$];

  int  err_cnt;
  int  cycle_cnt;
  int  src_idle_pct;
  int  snk_idle_pct;
  int  hold_left;
  bit  hold_req;
  bit  hold_seen;

  always #5 clk = ~clk;

  function automatic int home_slot(logic [KEY_W-1:0] k);
    return int'(k % SLOTS);
  endfunction

  function automatic void tbl_put(int i, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
    tbl_key[i]   = k;
    tbl_data[i]  = d;
    tbl_valid[i] = 1'b1;
  endfunction

  // caller guarantees a free slot exists
  function automatic void tbl_probe_put(int h, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
    int  i;
    bit  stop;
    i = h;
    stop = 1'b0;
    for (int n = 0; n < SLOTS && !stop; n++) begin
      if (!tbl_valid[i]) begin
        tbl_put(i, k, d);
        stop = 1'b1;
      end else begin
        i = (i + 1) % SLOTS;
      end
    end
  endfunction

  function automatic table_answer_t hash_table_apply(table_op_t op);
    table_answer_t     ans;
    int                h, i, j, hole, cnt;
    bit                any_free, stop;
    logic [KEY_W-1:0]  moved_key;
    logic [DATA_W-1:0] moved_data;
    ans = '{ST_NOTFOUND, '0, '0};
    h = home_slot(op.key);
    cnt = 0;
    case (op.func)
      FN_INSERT: begin
        any_free = 1'b0;
        for (int n = 0; n < SLOTS; n++)
          if (!tbl_valid[n]) any_free = 1'b1;
        if (!any_free) begin
          ans.status = ST_FULL;
        end else begin
          ans.status = ST_INSERTED;
          if (!tbl_valid[h]) begin
            tbl_put(h, op.key, op.payload);
          end else if (home_slot(tbl_key[h]) == h) begin
            tbl_probe_put(h, op.key, op.payload);
          end else begin
            // occupant sits away from its home: take the slot, re-probe the occupant
            moved_key  = tbl_key[h];
            moved_data = tbl_data[h];
            tbl_put(h, op.key, op.payload);
            tbl_probe_put(home_slot(moved_key), moved_key, moved_data);
          end
        end
      end
      FN_SEARCH: begin
        i = h;
        stop = 1'b0;
        cnt = SLOTS;
        for (int n = 1; n <= SLOTS && !stop; n++) begin
          if (!tbl_valid[i]) begin
            cnt = n;
            stop = 1'b1;
          end else if (tbl_key[i] == op.key) begin
            ans.status = ST_FOUND;
            ans.found_payload = tbl_data[i];
            cnt = n;
            stop = 1'b1;
          end else begin
            i = (i + 1) % SLOTS;
          end
        end
      end
      FN_DELETE: begin
        i = h;
        stop = 1'b0;
        for (int n = 0; n < SLOTS && !stop; n++) begin
          if (tbl_valid[i] && tbl_key[i] == op.key) begin
            ans.status = ST_DELETED;
            stop = 1'b1;
            hole = i;
            j = (i + 1) % SLOTS;
            // pull back only entries of the same home
            for (int m = 0; m + 1 < SLOTS && tbl_valid[j] && home_slot(tbl_key[j]) == h;
                 m++) begin
              tbl_put(hole, tbl_key[j], tbl_data[j]);
              hole = j;
              j = (j + 1) % SLOTS;
            end
            tbl_valid[hole] = 1'b0;
          end else if (!tbl_valid[i]) begin
            stop = 1'b1;
          end else begin
            i = (i + 1) % SLOTS;
          end
        end
      end
      default: ;
    endcase
    ans.probe_count = PCNT_W'((cnt > CNT_SAT) ? CNT_SAT : cnt);
    return ans;
  endfunction

  function automatic logic [KEY_W-1:0] key_at_home(int h);
    logic [KEY_W-1:0] k;
    k = KEY_W'({$urandom_range(0, 3), $urandom()});
    k[IDX_W-1:0] = IDX_W'(h);
    return k;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    err_cnt++;
  endtask

  // drive one request at a falling edge, return at the accepting rising edge
  task automatic send_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] p);
    table_op_t op;
    op = '{f, k, p};
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.func    <= f;
    req.key     <= k;
    req.payload <= p;
    do @(posedge clk); while (!req.ready);
    expected_answers.push_back(hash_table_apply(op));
  endtask

  task automatic wait_drained;
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases;
    logic [KEY_W-1:0] k_max;
    k_max = '1;
    src_idle_pct = 37;
    snk_idle_pct = 66;
    send_op(FN_SEARCH, '0, '0);                  // empty table
    send_op(FN_DELETE, '0, '0);
    send_op(FN_UNDEF, k_max, '1);
    send_op(FN_INSERT, k_max, '1);               // home 15
    send_op(FN_INSERT, 34'd9999999999, '0);      // home 15, wraps to slot 0
    send_op(FN_INSERT, 34'd31, 32'h1357_9bdf);   // home 15, slot 1
    send_op(FN_INSERT, '0, 32'ha5a5_5a5a);       // displaces the wrapped entry
    send_op(FN_SEARCH, 34'd9999999999, '0);
    send_op(FN_INSERT, 34'd31, 32'h2468_ace0);   // duplicate key
    send_op(FN_SEARCH, 34'd31, '0);              // first copy wins
    send_op(FN_DELETE, 34'd31, '0);              // pull-back of same-home run
    send_op(FN_SEARCH, 34'd31, '0);
    send_op(FN_SEARCH, 34'd16, '0);
    for (int h = 3; h < SLOTS - 1; h++)
      send_op(FN_INSERT, key_at_home(h), $urandom());
    send_op(FN_INSERT, key_at_home(7), $urandom()); // table full
    send_op(FN_SEARCH, key_at_home(5), '0);         // exhausted probe
    send_op(FN_DELETE, key_at_home(9), '0);
    wait_drained();
  endtask

  task automatic test_random_ops(int count, int src_pct, int snk_pct);
    logic [KEY_W-1:0]  pool[POOL_N];
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;
    int                base, ins_w, r;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    ins_w = 25;
    for (int n = 0; n < count; n++) begin
      // narrow home window so clusters, wraps and displacements are common
      if (n % 240 == 0) begin
        base = $urandom_range(0, SLOTS - 1);
        for (int p = 0; p < POOL_N; p++)
          pool[p] = key_at_home((base + $urandom_range(0, 5)) % SLOTS);
      end
      // alternate fill-heavy and drain-heavy stretches
      if (n % 60 == 0) ins_w = (ins_w == 70) ? 25 : 70;
      r = $urandom_range(0, 99);
      if (r < 3) f = FN_UNDEF;
      else if (r < ins_w) f = FN_INSERT;
      else if (r < ins_w + (100 - ins_w) / 2) f = FN_SEARCH;
      else f = FN_DELETE;
      if ($urandom_range(0, 9) == 0) k = key_at_home($urandom_range(0, SLOTS - 1));
      else k = pool[$urandom_range(0, POOL_N - 1)];
      send_op(f, k, $urandom());
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = ~hold_req;
    for (int n = 0; n < 16; n++)
      send_op((n % 3 == 2) ? FN_SEARCH : FN_INSERT, key_at_home($urandom_range(0, 3)),
              $urandom());
    wait_drained();
  endtask

  // response ready, with random stalls and an on-demand long hold-off
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (hold_req != hold_seen) begin
          hold_seen = hold_req;
          hold_left = HOLD_CYCLES;
        end
      end
    end
  end

  always @(posedge clk) begin : check_answers
    table_answer_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.probe_count, rsp.found_payload};
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected response", 64'(0), 64'(got));
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.probe_count !== want.probe_count)
          report_mismatch("probe_count", 64'(want.probe_count), 64'(got.probe_count));
        if (got.found_payload !== want.found_payload)
          report_mismatch("found_payload", 64'(want.found_payload),
                          64'(got.found_payload));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FN_INSERT;
    req.key = '0;
    req.payload = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_ops(620, 37, 66);
    test_random_ops(620, 66, 37);
    test_backpressure();
    test_random_ops(610, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lph_pkg.sv
hdl/lph_if.sv
hdl/lph_dp.sv
hdl/lph_ctrl.sv
hdl/linear_probe_hash_with_replacement.sv
tb/sv/tb_linear_probe_hash_with_replacement.sv
